[rtl/itp_pkg.sv]
// Shared types and constants for the infix to postfix converter.
`default_nettype none

package itp_pkg;

    // Operator stack geometry
    localparam int STACK_DEPTH = 32;
    localparam int STK_IDX_W   = $clog2(STACK_DEPTH);
    localparam int STK_CNT_W   = $clog2(STACK_DEPTH + 1);

    // Operator codes as held on the stack
    typedef enum logic [2:0] {
        OP_OPEN = 3'd0,
        OP_ADD  = 3'd1,
        OP_SUB  = 3'd2,
        OP_MUL  = 3'd3,
        OP_DIV  = 3'd4,
        OP_POW  = 3'd5
    } t_op;

    // Error codes carried in a result word
    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_BAD_CHAR = 2'd1;
    localparam logic [1:0] ERR_UNMATCH  = 2'd2;
    localparam logic [1:0] ERR_OVERFLOW = 2'd3;

    // Input word
    typedef struct packed {
        logic [7:0] token_char;
        logic       end_of_expr;
    } t_in_item;

    // Result word
    typedef struct packed {
        logic [7:0] postfix_char;
        logic       expr_done;
        logic [1:0] error_code;
        logic       is_last;
    } t_out_item;

    // Stack command from the controller
    typedef struct packed {
        logic clear;
        logic push;
        logic pop;
        t_op  code;
    } t_stk_cmd;

    // Stack status towards the controller
    typedef struct packed {
        t_op                  top;
        t_op                  below;
        logic [STK_CNT_W-1:0] count;
    } t_stk_stat;

endpackage

`default_nettype wire

[rtl/itp_stack.sv]
// Operator stack: memory with cached top and prefetched entry below the top.
`default_nettype none

module itp_stack (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire itp_pkg::t_stk_cmd    i_cmd,
    output itp_pkg::t_stk_stat        o_stat
);

    localparam int IW = itp_pkg::STK_IDX_W;
    localparam int CW = itp_pkg::STK_CNT_W;

    itp_pkg::t_op mem [itp_pkg::STACK_DEPTH];

    logic [CW-1:0] r_count, n_count;
    itp_pkg::t_op  r_top, n_top;
    itp_pkg::t_op  r_rdata;
    itp_pkg::t_op  w_below;
    logic [CW-1:0] w_raddr_full;

    // Entry zero is the sentinel and is never stored
    assign w_below = (r_count == CW'(2)) ? itp_pkg::OP_OPEN : r_rdata;

    // Work out next count and top
    always_comb begin
        n_count = r_count;
        n_top   = r_top;
        if (i_cmd.clear) begin
            n_count = CW'(1);
            n_top   = itp_pkg::OP_OPEN;
        end else if (i_cmd.push) begin
            n_count = r_count + CW'(1);
            n_top   = i_cmd.code;
        end else if (i_cmd.pop) begin
            n_count = r_count - CW'(1);
            n_top   = w_below;
        end
    end

    // Prefetch the entry below the next top
    assign w_raddr_full = n_count - CW'(2);

    // Hold count and cached top
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= CW'(1);
            r_top   <= itp_pkg::OP_OPEN;
        end else begin
            r_count <= n_count;
            r_top   <= n_top;
        end
    end

    // Write pushed code, read entry below top
    always_ff @(posedge i_clk) begin
        if (i_cmd.push && !i_cmd.clear) begin
            mem[r_count[IW-1:0]] <= i_cmd.code;
        end
        r_rdata <= mem[w_raddr_full[IW-1:0]];
    end

    assign o_stat.top   = r_top;
    assign o_stat.below = w_below;
    assign o_stat.count = r_count;

endmodule

`default_nettype wire

[rtl/infix_to_postfix_converter_core.sv]
// Top level: shunting-yard infix to postfix converter with output register.
// An accepted word is registered and evaluated in S_EVAL; each result word is
// loaded into the output register, and back-pressure stalls any step that emits.
// Each silently dropped open parenthesis and each popped entry takes its own step;
// the stack's prefetch of the entry below top lets such pops run back to back.
// Reset: stack returns to the sentinel alone at once; no memory clearing pass.
`default_nettype none

module infix_to_postfix_converter_core (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_in_valid,
    output logic                     o_in_ready,
    input  wire itp_pkg::t_in_item   i_in_data,
    output logic                     o_out_valid,
    input  wire                      i_out_ready,
    output itp_pkg::t_out_item       o_out_data
);

    localparam int CW = itp_pkg::STK_CNT_W;

    // Character constants
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_OPEN  = 8'h28;
    localparam logic [7:0] CH_CLOSE = 8'h29;
    localparam logic [7:0] CH_MUL   = 8'h2A;
    localparam logic [7:0] CH_ADD   = 8'h2B;
    localparam logic [7:0] CH_SUB   = 8'h2D;
    localparam logic [7:0] CH_DIV   = 8'h2F;
    localparam logic [7:0] CH_POW   = 8'h5E;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UZ    = 8'h5A;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LZ    = 8'h7A;

    typedef enum logic [2:0] {
        K_LETTER,
        K_SPACE,
        K_OPEN,
        K_CLOSE,
        K_OPER,
        K_BAD
    } t_kind;

    typedef enum logic {
        S_IDLE,
        S_EVAL
    } t_state;

    function automatic t_kind tok_kind(input logic [7:0] ch);
        t_kind k;
        if (ch inside {[CH_UA:CH_UZ], [CH_LA:CH_LZ]}) begin
            k = K_LETTER;
        end else begin
            case (ch)
                CH_SPACE: k = K_SPACE;
                CH_OPEN:  k = K_OPEN;
                CH_CLOSE: k = K_CLOSE;
                CH_ADD, CH_SUB, CH_MUL, CH_DIV, CH_POW: k = K_OPER;
                default:  k = K_BAD;
            endcase
        end
        return k;
    endfunction

    function automatic itp_pkg::t_op tok_op(input logic [7:0] ch);
        itp_pkg::t_op op;
        case (ch)
            CH_ADD:  op = itp_pkg::OP_ADD;
            CH_SUB:  op = itp_pkg::OP_SUB;
            CH_MUL:  op = itp_pkg::OP_MUL;
            CH_DIV:  op = itp_pkg::OP_DIV;
            CH_POW:  op = itp_pkg::OP_POW;
            default: op = itp_pkg::OP_OPEN;
        endcase
        return op;
    endfunction

    function automatic logic [7:0] op_char(input itp_pkg::t_op op);
        logic [7:0] c;
        case (op)
            itp_pkg::OP_OPEN: c = CH_OPEN;
            itp_pkg::OP_ADD:  c = CH_ADD;
            itp_pkg::OP_SUB:  c = CH_SUB;
            itp_pkg::OP_MUL:  c = CH_MUL;
            itp_pkg::OP_DIV:  c = CH_DIV;
            itp_pkg::OP_POW:  c = CH_POW;
            default:          c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [1:0] op_prec(input itp_pkg::t_op op);
        logic [1:0] p;
        case (op)
            itp_pkg::OP_ADD, itp_pkg::OP_SUB: p = 2'd1;
            itp_pkg::OP_MUL, itp_pkg::OP_DIV: p = 2'd2;
            itp_pkg::OP_POW:                  p = 2'd3;
            default:                          p = 2'd0;
        endcase
        return p;
    endfunction

    t_state              r_state, n_state;
    logic [7:0]          r_ch;
    logic                r_eoe;
    logic                r_out_valid, n_out_valid;
    itp_pkg::t_out_item  r_out, n_out;

    itp_pkg::t_stk_cmd   w_cmd, w_cmd_go;
    itp_pkg::t_stk_stat  w_stk;
    itp_pkg::t_out_item  w_emit;
    logic                w_want_emit;
    logic                w_fin;
    logic                w_can_emit;
    logic                w_go;
    t_kind               w_kind;
    itp_pkg::t_op        w_code;

    itp_stack u_stack (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd_go),
        .o_stat  (w_stk)
    );

    assign w_kind     = tok_kind(r_ch);
    assign w_code     = tok_op(r_ch);
    assign w_can_emit = !r_out_valid || i_out_ready;

    // Decide one step of the current word
    always_comb begin
        w_want_emit = 1'b0;
        w_emit      = '0;
        w_cmd       = '0;
        w_fin       = 1'b0;
        if (r_state == S_EVAL) begin
            if (r_eoe) begin
                // Flush down to the sentinel, then mark done
                if (w_stk.count > CW'(1)) begin
                    w_cmd.pop = 1'b1;
                    if (w_stk.top != itp_pkg::OP_OPEN) begin
                        w_want_emit         = 1'b1;
                        w_emit.postfix_char = op_char(w_stk.top);
                    end
                end else begin
                    w_want_emit      = 1'b1;
                    w_emit.expr_done = 1'b1;
                    w_emit.is_last   = 1'b1;
                    w_cmd.clear      = 1'b1;
                    w_fin            = 1'b1;
                end
            end else begin
                case (w_kind)
                    K_LETTER: begin
                        w_want_emit         = 1'b1;
                        w_emit.postfix_char = r_ch;
                        w_emit.is_last      = 1'b1;
                        w_fin               = 1'b1;
                    end
                    K_SPACE: begin
                        w_fin = 1'b1;
                    end
                    K_OPEN, K_OPER: begin
                        if (w_kind == K_OPER &&
                            op_prec(w_stk.top) >= op_prec(w_code)) begin
                            // Pop an operator of equal or higher precedence
                            w_want_emit         = 1'b1;
                            w_emit.postfix_char = op_char(w_stk.top);
                            w_emit.is_last      = op_prec(w_stk.below) < op_prec(w_code);
                            w_cmd.pop           = 1'b1;
                        end else if (w_stk.count >= CW'(itp_pkg::STACK_DEPTH)) begin
                            w_want_emit       = 1'b1;
                            w_emit.error_code = itp_pkg::ERR_OVERFLOW;
                            w_emit.is_last    = 1'b1;
                            w_cmd.clear       = 1'b1;
                            w_fin             = 1'b1;
                        end else begin
                            w_cmd.push = 1'b1;
                            w_cmd.code = (w_kind == K_OPEN) ? itp_pkg::OP_OPEN : w_code;
                            w_fin      = 1'b1;
                        end
                    end
                    K_CLOSE: begin
                        if (w_stk.top == itp_pkg::OP_OPEN) begin
                            if (w_stk.count <= CW'(1)) begin
                                w_want_emit       = 1'b1;
                                w_emit.error_code = itp_pkg::ERR_UNMATCH;
                                w_emit.is_last    = 1'b1;
                                w_cmd.clear       = 1'b1;
                            end else begin
                                w_cmd.pop = 1'b1;
                            end
                            w_fin = 1'b1;
                        end else begin
                            w_want_emit         = 1'b1;
                            w_emit.postfix_char = op_char(w_stk.top);
                            w_emit.is_last      = (w_stk.below == itp_pkg::OP_OPEN) &&
                                                  (w_stk.count > CW'(2));
                            w_cmd.pop           = 1'b1;
                        end
                    end
                    default: begin
                        w_want_emit       = 1'b1;
                        w_emit.error_code = itp_pkg::ERR_BAD_CHAR;
                        w_emit.is_last    = 1'b1;
                        w_cmd.clear       = 1'b1;
                        w_fin             = 1'b1;
                    end
                endcase
            end
        end
    end

    // Stall the whole step while it has a word to emit and the output register is blocked
    assign w_go     = !w_want_emit || w_can_emit;
    assign w_cmd_go = w_go ? w_cmd : '0;

    // Next state and output register
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (w_go && w_want_emit) begin
            n_out_valid = 1'b1;
            n_out       = w_emit;
        end
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                if (w_go && w_fin) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
        r_out <= n_out;
        if (r_state == S_IDLE && i_in_valid) begin
            r_ch  <= i_in_data.token_char;
            r_eoe <= i_in_data.end_of_expr;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Stack count stays within sentinel-only and full
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_stk.count >= CW'(1)) && (w_stk.count <= CW'(itp_pkg::STACK_DEPTH)))
        else $error("stack count out of range");

    // With the sentinel alone the top reads as open paren
    a_sentinel_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_stk.count == CW'(1)) |-> (w_stk.top == itp_pkg::OP_OPEN))
        else $error("sentinel not on top of empty stack");

    // Error and done words carry no character and close their input
    a_marker_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.expr_done || r_out.error_code != itp_pkg::ERR_NONE))
        |-> (r_out.postfix_char == 8'h00 && r_out.is_last))
        else $error("malformed done or error word");

    // A loaded word never overwrites one not yet taken
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |=> ($stable(r_out) && r_out_valid))
        else $error("output word overwritten");

endmodule

`default_nettype wire

[bench/itp_postfix_checker.sv]
`timescale 1ns / 100ps
// Checker for the infix to postfix converter: predicts result words and compares them.
module itp_postfix_checker (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    input  wire                 i_in_ready,
    input  itp_pkg::t_in_item   i_in_data,
    input  wire                 i_out_valid,
    input  wire                 i_out_ready,
    input  itp_pkg::t_out_item  i_out_data,
    output int                  o_fail_count,
    output int                  o_pending
);

    localparam logic [7:0] CH_SPACE = " ";
    localparam logic [7:0] CH_OPEN  = "(";
    localparam logic [7:0] CH_CLOSE = ")";
    localparam logic [7:0] CH_ADD   = "+";
    localparam logic [7:0] CH_SUB   = "-";
    localparam logic [7:0] CH_MUL   = "*";
    localparam logic [7:0] CH_DIV   = "/";
    localparam logic [7:0] CH_POW   = "^";

    itp_pkg::t_op       op_stack [0:63];
    int                 stack_fill;
    itp_pkg::t_out_item postfix_q[$];
    itp_pkg::t_out_item step_words[$];
    int                 mismatch_total;

    initial begin
        mismatch_total = 0;
        o_fail_count   = 0;
        o_pending      = 0;
        stack_fill     = 1;
        op_stack[0]    = itp_pkg::OP_OPEN;
    end

    // Drop everything above the sentinel
    task automatic clear_stack();
        stack_fill  = 1;
        op_stack[0] = itp_pkg::OP_OPEN;
    endtask

    function automatic logic [7:0] op_symbol(input itp_pkg::t_op code);
        case (code)
            itp_pkg::OP_ADD: return CH_ADD;
            itp_pkg::OP_SUB: return CH_SUB;
            itp_pkg::OP_MUL: return CH_MUL;
            itp_pkg::OP_DIV: return CH_DIV;
            itp_pkg::OP_POW: return CH_POW;
            default:         return CH_OPEN;
        endcase
    endfunction

    function automatic int op_rank(input itp_pkg::t_op code);
        case (code)
            itp_pkg::OP_ADD, itp_pkg::OP_SUB: return 1;
            itp_pkg::OP_MUL, itp_pkg::OP_DIV: return 2;
            itp_pkg::OP_POW:                  return 3;
            default:                          return 0;
        endcase
    endfunction

    task automatic emit_word(input logic [7:0] ch, input logic done, input logic [1:0] err);
        itp_pkg::t_out_item w;
        w.postfix_char = ch;
        w.expr_done    = done;
        w.error_code   = err;
        w.is_last      = 1'b0;
        step_words.push_back(w);
    endtask

    // Push, or flag an overflow and fall back to the sentinel
    task automatic push_operator(input itp_pkg::t_op code);
        if (stack_fill >= itp_pkg::STACK_DEPTH) begin
            emit_word(8'd0, 1'b0, itp_pkg::ERR_OVERFLOW);
            clear_stack();
        end else begin
            op_stack[stack_fill] = code;
            stack_fill++;
        end
    endtask

    // Work out the postfix words caused by one input word
    task automatic predict_postfix(input itp_pkg::t_in_item w);
        itp_pkg::t_op       code;
        logic               known;
        logic               closing;
        itp_pkg::t_out_item tail;
        step_words.delete();
        if (w.end_of_expr) begin
            // flush down to the sentinel, silently dropping open parentheses
            while (stack_fill > 1) begin
                code = op_stack[stack_fill - 1];
                stack_fill--;
                if (code != itp_pkg::OP_OPEN)
                    emit_word(op_symbol(code), 1'b0, itp_pkg::ERR_NONE);
            end
            emit_word(8'd0, 1'b1, itp_pkg::ERR_NONE);
            clear_stack();
        end else if ((w.token_char >= "A" && w.token_char <= "Z") ||
                     (w.token_char >= "a" && w.token_char <= "z")) begin
            emit_word(w.token_char, 1'b0, itp_pkg::ERR_NONE);
        end else if (w.token_char == CH_OPEN) begin
            push_operator(itp_pkg::OP_OPEN);
        end else if (w.token_char == CH_CLOSE) begin
            // pop to the nearest open parenthesis; the sentinel means unmatched
            closing = 1'b1;
            while (closing) begin
                code = op_stack[stack_fill - 1];
                if (code == itp_pkg::OP_OPEN) begin
                    if (stack_fill <= 1) begin
                        emit_word(8'd0, 1'b0, itp_pkg::ERR_UNMATCH);
                        clear_stack();
                    end else begin
                        stack_fill--;
                    end
                    closing = 1'b0;
                end else begin
                    emit_word(op_symbol(code), 1'b0, itp_pkg::ERR_NONE);
                    stack_fill--;
                end
            end
        end else if (w.token_char != CH_SPACE) begin
            known = 1'b1;
            code  = itp_pkg::OP_OPEN;
            case (w.token_char)
                CH_ADD:  code = itp_pkg::OP_ADD;
                CH_SUB:  code = itp_pkg::OP_SUB;
                CH_MUL:  code = itp_pkg::OP_MUL;
                CH_DIV:  code = itp_pkg::OP_DIV;
                CH_POW:  code = itp_pkg::OP_POW;
                default: known = 1'b0;
            endcase
            if (!known) begin
                emit_word(8'd0, 1'b0, itp_pkg::ERR_BAD_CHAR);
                clear_stack();
            end else begin
                // left-associative: pop while the stacked rank is not lower
                while (stack_fill > 1 &&
                       op_rank(op_stack[stack_fill - 1]) >= op_rank(code)) begin
                    emit_word(op_symbol(op_stack[stack_fill - 1]), 1'b0, itp_pkg::ERR_NONE);
                    stack_fill--;
                end
                push_operator(code);
            end
        end
        // mark the last word of this step
        if (step_words.size() > 0) begin
            tail          = step_words[$];
            tail.is_last  = 1'b1;
            step_words[$] = tail;
        end
        foreach (step_words[k])
            postfix_q.push_back(step_words[k]);
    endtask

    task automatic report_mismatch(input string what, input logic [11:0] got,
                                   input logic [11:0] want);
        $display("%0t ns: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
        mismatch_total++;
    endtask

    // Compare one result word with the oldest pending expectation
    task automatic check_postfix(input itp_pkg::t_out_item got);
        itp_pkg::t_out_item want;
        if (postfix_q.size() == 0) begin
            report_mismatch("unexpected result word", got, 12'd0);
        end else begin
            want = postfix_q.pop_front();
            if (got.postfix_char !== want.postfix_char)
                report_mismatch("postfix_char", 12'(got.postfix_char),
                                12'(want.postfix_char));
            if (got.expr_done !== want.expr_done)
                report_mismatch("expr_done", 12'(got.expr_done), 12'(want.expr_done));
            if (got.error_code !== want.error_code)
                report_mismatch("error_code", 12'(got.error_code), 12'(want.error_code));
            if (got.is_last !== want.is_last)
                report_mismatch("is_last", 12'(got.is_last), 12'(want.is_last));
        end
    endtask

    // Predict on each accepted input word, check each accepted result word
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_stack();
            postfix_q.delete();
        end else begin
            if (i_in_valid && i_in_ready)
                predict_postfix(i_in_data);
            if (i_out_valid && i_out_ready)
                check_postfix(i_out_data);
        end
        o_fail_count <= mismatch_total;
        o_pending    <= postfix_q.size();
    end

endmodule

[bench/infix_to_postfix_converter_core_test.sv]
`timescale 1ns / 100ps
// Top of the converter testbench: clock, reset, stimulus, result back-pressure and verdict.
module infix_to_postfix_converter_core_test;

    localparam int ITEM_TARGET  = 310;
    localparam int STALL_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 40;

    localparam logic [7:0] CH_SPACE = " ";
    localparam logic [7:0] CH_OPEN  = "(";
    localparam logic [7:0] CH_CLOSE = ")";
    localparam logic [7:0] CH_ADD   = "+";
    localparam logic [7:0] CH_SUB   = "-";
    localparam logic [7:0] CH_MUL   = "*";
    localparam logic [7:0] CH_DIV   = "/";
    localparam logic [7:0] CH_POW   = "^";

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    itp_pkg::t_in_item  in_data;
    logic               out_valid;
    logic               out_ready;
    itp_pkg::t_out_item out_data;
    int                 fail_count;
    int                 pending;
    int                 idle_cycles;
    int                 words_sent;
    bit                 calm;
    bit                 sprinkle;
    itp_pkg::t_in_item  token_q[$];

    infix_to_postfix_converter_core DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_data  (out_data)
    );

    itp_postfix_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_ready   (in_ready),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_ready  (out_ready),
        .i_out_data   (out_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Mostly short gaps, a few long ones, none in calm stretches
    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] random_letter();
        if ($urandom_range(0, 1))
            return 8'("A" + $urandom_range(0, 25));
        return 8'("a" + $urandom_range(0, 25));
    endfunction

    function automatic logic [7:0] random_operator();
        case ($urandom_range(0, 4))
            0:       return CH_ADD;
            1:       return CH_SUB;
            2:       return CH_MUL;
            3:       return CH_DIV;
            default: return CH_POW;
        endcase
    endfunction

    // Queue a character word, sometimes behind a space
    task automatic queue_char(input logic [7:0] ch);
        itp_pkg::t_in_item w;
        w.end_of_expr = 1'b0;
        if (sprinkle && $urandom_range(0, 7) == 0) begin
            w.token_char = CH_SPACE;
            token_q.push_back(w);
        end
        w.token_char = ch;
        token_q.push_back(w);
    endtask

    task automatic queue_end(input logic [7:0] ch);
        itp_pkg::t_in_item w;
        w.token_char  = ch;
        w.end_of_expr = 1'b1;
        token_q.push_back(w);
    endtask

    task automatic queue_text(input string s);
        for (int i = 0; i < s.len(); i++)
            queue_char(s[i]);
    endtask

    // Hand over every queued word, holding valid and data until accepted
    task automatic send_queued();
        itp_pkg::t_in_item w;
        int                gap;
        while (token_q.size() > 0) begin
            w   = token_q.pop_front();
            gap = idle_gap();
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            in_valid <= 1'b1;
            in_data  <= w;
            do
                @(posedge clk);
            while (!in_ready);
            words_sent++;
            @(negedge clk);
        end
    endtask

    initial begin : stimulus
        int kind;
        int n;
        int opens;
        int r;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_data    = '0;
        words_sent = 0;
        calm       = 1'b0;
        sprinkle   = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: every operator, letter extremes, unmatched close, space,
        // bad characters, an end with a junk token, unclosed parentheses
        queue_text("a+b*c^d-e/f");
        queue_end(8'h00);
        queue_text("(A)) ");
        queue_char(8'h00);
        queue_char(8'hFF);
        queue_end(8'hFF);
        queue_text("((Z+z");
        queue_end(8'h00);
        send_queued();

        // Random sequences, mostly well formed
        sprinkle = 1'b1;
        while (words_sent < ITEM_TARGET) begin
            calm = ($urandom_range(0, 7) == 0);
            kind = $urandom_range(0, 99);
            if (kind < 60) begin
                // expression with nested parentheses, sometimes left unclosed
                opens = 0;
                n     = $urandom_range(1, 8);
                for (int i = 0; i < n; i++) begin
                    while (opens < 4 && $urandom_range(0, 3) == 0) begin
                        queue_char(CH_OPEN);
                        opens++;
                    end
                    queue_char(random_letter());
                    while (opens > 0 && $urandom_range(0, 2) == 0) begin
                        queue_char(CH_CLOSE);
                        opens--;
                    end
                    if (i < n - 1)
                        queue_char(random_operator());
                end
                if ($urandom_range(0, 4) != 0)
                    repeat (opens) queue_char(CH_CLOSE);
                queue_end(8'($urandom_range(0, 255)));
            end else if (kind < 72) begin
                // deep stack: long flushes and overflow
                n = $urandom_range(16, 36);
                repeat (n) begin
                    r = $urandom_range(0, 9);
                    if (r < 5)
                        queue_char(CH_OPEN);
                    else if (r < 8)
                        queue_char(random_operator());
                    else
                        queue_char(random_letter());
                end
                if ($urandom_range(0, 3) == 0)
                    repeat ($urandom_range(1, 8)) queue_char(CH_CLOSE);
                queue_end(8'($urandom_range(0, 255)));
            end else if (kind < 87) begin
                // broken sequence from the legal alphabet
                n = $urandom_range(3, 12);
                repeat (n) begin
                    case ($urandom_range(0, 4))
                        0:       queue_char(random_operator());
                        1:       queue_char(CH_OPEN);
                        2:       queue_char(CH_CLOSE);
                        3:       queue_char(CH_SPACE);
                        default: queue_char(random_letter());
                    endcase
                end
                if ($urandom_range(0, 1))
                    queue_end(8'($urandom_range(0, 255)));
            end else begin
                // raw bytes
                n = $urandom_range(1, 6);
                repeat (n) begin
                    if ($urandom_range(0, 3) == 0)
                        queue_end(8'($urandom_range(0, 255)));
                    else
                        queue_char(8'($urandom_range(0, 255)));
                end
            end
            send_queued();
        end
        in_valid <= 1'b0;

        // Drain and give the verdict
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // Result back-pressure: ready bursts with random stalls between
    initial begin : result_sink
        int burst;
        int gap;
        out_ready = 1'b0;
        @(negedge clk);
        forever begin
            out_ready <= 1'b1;
            burst = $urandom_range(1, 12);
            repeat (burst) @(negedge clk);
            gap = idle_gap();
            if (gap > 0) begin
                out_ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
    end

    // Watchdog: end the run if no word moves on either channel for too long
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= STALL_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

endmodule

[files.f]
rtl/itp_pkg.sv
rtl/itp_stack.sv
rtl/infix_to_postfix_converter_core.sv
bench/itp_postfix_checker.sv
bench/infix_to_postfix_converter_core_test.sv
